[hdl/dbp_pkg.sv]
`default_nettype none
package dbp_pkg;

    // Field widths fixed by the item formats
    localparam int unsigned LOGIT_W  = 16;
    localparam int unsigned GEO_W    = 32;
    localparam int unsigned IMG_W    = 14;
    localparam int unsigned MSIZE_W  = 13;
    localparam int unsigned SCORE_W  = 16;
    localparam int unsigned CLASS_W  = 8;
    localparam int unsigned EDGE_W   = 30;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 2'd2;

    // Sigmoid: exp(-a) built from one factor per logit magnitude bit
    localparam int unsigned EXP_BITS       = 12;
    localparam int unsigned FRONT_DIV_BITS = 17;
    // Edge mapping: quotient bits once the clamp has been ruled out
    localparam int unsigned BACK_DIV_BITS  = 30;
    // Scale box by model size when every value is at most 1.0 in Q16.16
    localparam logic signed [GEO_W-1:0] UNIT_Q16 = 32'sd65536;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] class_logit;
        logic                      last_class;
        logic                      last_box;
        logic signed [GEO_W-1:0]   center_x;
        logic signed [GEO_W-1:0]   center_y;
        logic signed [GEO_W-1:0]   box_width;
        logic signed [GEO_W-1:0]   box_height;
        logic [IMG_W-1:0]          image_width;
        logic [IMG_W-1:0]          image_height;
    } t_in_word;

    typedef struct packed {
        logic                detected;
        logic [EDGE_W-1:0]   left;
        logic [EDGE_W-1:0]   top;
        logic [EDGE_W-1:0]   right;
        logic [EDGE_W-1:0]   bottom;
        logic [SCORE_W-1:0]  best_score_out;
        logic [CLASS_W-1:0]  best_class_out;
        logic                end_of_image;
    } t_out_word;

    // One finished box handed from front to back
    typedef struct packed {
        logic                    detected;
        logic [SCORE_W-1:0]      score;
        logic [CLASS_W-1:0]      class_idx;
        logic signed [GEO_W-1:0] center_x;
        logic signed [GEO_W-1:0] center_y;
        logic signed [GEO_W-1:0] box_width;
        logic signed [GEO_W-1:0] box_height;
        logic [IMG_W-1:0]        image_width;
        logic [IMG_W-1:0]        image_height;
        logic                    last_box;
    } t_box_job;

    typedef enum logic [2:0] {
        F_IDLE,
        F_EXP,
        F_DSET,
        F_DIV,
        F_CMP,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCALE,
        B_TWICE,
        B_PROD,
        B_LIMIT,
        B_DIV,
        B_OUT
    } t_back_state;

    // exp(-2^(b-8)) in Q0.32
    function automatic logic [31:0] exp_const(input logic [3:0] b);
        logic [31:0] k;
        case (b)
            4'd0:    k = 32'd4278222805;
            4'd1:    k = 32'd4261543595;
            4'd2:    k = 32'd4228380000;
            4'd3:    k = 32'd4162825044;
            4'd4:    k = 32'd4034748382;
            4'd5:    k = 32'd3790295335;
            4'd6:    k = 32'd3344923893;
            4'd7:    k = 32'd2605029347;
            4'd8:    k = 32'd1580030169;
            4'd9:    k = 32'd581260615;
            4'd10:   k = 32'd78665070;
            4'd11:   k = 32'd1440801;
            default: k = 32'd0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

[hdl/dbp_front.sv]
`default_nettype none
module dbp_front
    import dbp_pkg::*;
#(
    parameter int unsigned MAX_CLASSES = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_in_word            i_in_word,
    input  wire logic [SCORE_W-1:0]  i_score_threshold,
    output logic                     o_job_valid,
    input  wire logic                i_job_ready,
    output t_box_job                 o_job
);

    localparam int unsigned CNT_W = $clog2(MAX_CLASSES + 1);

    t_front_state       r_state, n_state;
    t_in_word           r_item;
    logic               r_compete;
    logic               r_pos;
    logic [EXP_BITS-1:0] r_mag;
    logic [4:0]         r_cnt;
    logic [31:0]        r_e;
    logic               r_e_one;
    logic [33:0]        r_den;
    logic [32:0]        r_rem;
    logic [FRONT_DIV_BITS-1:0] r_dq;
    logic [SCORE_W-1:0] r_score;
    logic [CNT_W-1:0]   r_count;
    logic [SCORE_W-1:0] r_best_score;
    logic [CLASS_W-1:0] r_best_class;
    logic               r_any;

    logic [16:0] w_ext;
    logic [16:0] w_mag;
    logic        w_sat;
    logic        w_compete;
    logic [31:0] w_k;
    logic [63:0] w_prod;
    logic [32:0] w_efull;
    logic [33:0] w_den;
    logic [48:0] w_num;
    logic [48:0] w_n;
    logic [33:0] w_rem2;
    logic        w_ge;
    logic [FRONT_DIV_BITS-1:0] w_q;
    logic        w_win;

    assign w_ext     = {i_in_word.class_logit[LOGIT_W-1], i_in_word.class_logit};
    assign w_mag     = w_ext[16] ? (~w_ext + 17'd1) : w_ext;
    assign w_sat     = |w_mag[16:EXP_BITS];
    assign w_compete = r_count < CNT_W'(MAX_CLASSES);

    // One rounded Q0.32 product per magnitude bit
    assign w_k    = exp_const(r_cnt[3:0]);
    assign w_prod = {32'd0, r_e} * {32'd0, w_k} + 64'h0000_0000_8000_0000;

    assign w_efull = r_e_one ? 33'h1_0000_0000 : {1'b0, r_e};
    assign w_den   = 34'h1_0000_0000 + {1'b0, w_efull};
    assign w_num   = r_pos ? 49'h1_0000_0000_0000 : {w_efull, 16'd0};
    assign w_n     = w_num + {16'd0, w_den[33:1]};

    assign w_rem2 = {r_rem, r_dq[FRONT_DIV_BITS-1]};
    assign w_ge   = w_rem2 >= r_den;
    assign w_q    = {r_dq[FRONT_DIV_BITS-2:0], w_ge};

    assign w_win = (r_score > r_best_score) && (r_score > i_score_threshold);

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    n_state = (!w_compete || w_sat) ? F_CMP : F_EXP;
                end
            end
            F_EXP: begin
                if (r_cnt == 5'(EXP_BITS - 1)) begin
                    n_state = F_DSET;
                end
            end
            F_DSET: n_state = F_DIV;
            F_DIV: begin
                if (r_cnt == 5'(FRONT_DIV_BITS - 1)) begin
                    n_state = F_CMP;
                end
            end
            F_CMP:  n_state = r_item.last_class ? F_PUSH : F_IDLE;
            F_PUSH: begin
                if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == F_IDLE);
        o_job_valid = (r_state == F_PUSH);
    end

    assign o_job = '{
        detected:     r_any,
        score:        r_best_score,
        class_idx:    r_best_class,
        center_x:     r_item.center_x,
        center_y:     r_item.center_y,
        box_width:    r_item.box_width,
        box_height:   r_item.box_height,
        image_width:  r_item.image_width,
        image_height: r_item.image_height,
        last_box:     r_item.last_box
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_count      <= '0;
            r_best_score <= '0;
            r_best_class <= '0;
            r_any        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == F_CMP && r_compete) begin
                if (w_win) begin
                    r_best_score <= r_score;
                    r_best_class <= CLASS_W'(r_count);
                    r_any        <= 1'b1;
                end
                r_count <= r_count + CNT_W'(1);
            end
            if (r_state == F_PUSH && i_job_ready) begin
                r_count      <= '0;
                r_best_score <= '0;
                r_best_class <= '0;
                r_any        <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    r_item    <= i_in_word;
                    r_compete <= w_compete;
                    r_pos     <= ~w_ext[16];
                    r_mag     <= w_mag[EXP_BITS-1:0];
                    r_e_one   <= 1'b1;
                    r_cnt     <= '0;
                    r_score   <= w_ext[16] ? '0 : '1;
                end
            end
            F_EXP: begin
                if (r_mag[r_cnt[3:0]]) begin
                    r_e     <= r_e_one ? w_k : w_prod[63:32];
                    r_e_one <= 1'b0;
                end
                r_cnt <= (r_cnt == 5'(EXP_BITS - 1)) ? 5'd0 : r_cnt + 5'd1;
            end
            F_DSET: begin
                r_den <= w_den;
                r_rem <= {1'b0, w_n[48:FRONT_DIV_BITS]};
                r_dq  <= w_n[FRONT_DIV_BITS-1:0];
                r_cnt <= '0;
            end
            F_DIV: begin
                r_rem <= w_ge ? 33'(w_rem2 - r_den) : w_rem2[32:0];
                r_dq  <= w_q;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(FRONT_DIV_BITS - 1)) begin
                    r_score <= w_q[FRONT_DIV_BITS-1] ? '1 : w_q[SCORE_W-1:0];
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[hdl/dbp_fifo.sv]
`default_nettype none
module dbp_fifo
    import dbp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_wr_valid,
    output logic          o_wr_ready,
    input  wire t_box_job i_wr_job,
    output logic          o_rd_valid,
    input  wire logic     i_rd_ready,
    output t_box_job      o_rd_job
);

    t_box_job            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_fill;
    logic                w_push;
    logic                w_pop;

    assign o_wr_ready = r_fill != (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_rd_valid = r_fill != '0;
    assign o_rd_job   = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + (QPTR_W+1)'(1);
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

endmodule
`default_nettype wire

[hdl/dbp_back.sv]
`default_nettype none
module dbp_back
    import dbp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_job_valid,
    output logic                    o_job_ready,
    input  wire t_box_job           i_job,
    input  wire logic [MSIZE_W-1:0] i_model_width,
    input  wire logic [MSIZE_W-1:0] i_model_height,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out_word               o_out_word
);

    t_back_state              r_state, n_state;
    t_box_job                 r_job;
    logic                     r_scale;
    logic [1:0]               r_edge_idx;
    logic signed [45:0]       r_c2;
    logic signed [45:0]       r_s2;
    logic signed [47:0]       r_twice;
    logic                     r_pos;
    logic [60:0]              r_num;
    logic [44:0]              r_limprod;
    logic [EDGE_W-1:0]        r_lim;
    logic [13:0]              r_div_d;
    logic [13:0]              r_rem;
    logic [BACK_DIV_BITS-1:0] r_dq;
    logic [4:0]               r_cnt;
    logic [EDGE_W-1:0]        r_edge [4];
    logic                     r_out_valid;
    t_out_word                r_out;

    logic                     w_is_y;
    logic [MSIZE_W-1:0]       w_m;
    logic [MSIZE_W-1:0]       w_m1;
    logic signed [13:0]       w_m_s;
    logic signed [GEO_W-1:0]  w_c;
    logic signed [GEO_W-1:0]  w_s;
    logic [IMG_W-1:0]         w_img;
    logic signed [45:0]       w_c_prod;
    logic signed [45:0]       w_s_prod;
    logic signed [47:0]       w_c2x2;
    logic signed [47:0]       w_s2e;
    logic [13:0]              w_d;
    logic [EDGE_W-1:0]        w_lim;
    logic [30:0]              w_limp1;
    logic [60:0]              w_num;
    logic [44:0]              w_limprod;
    logic                     w_over;
    logic [14:0]              w_rem2;
    logic                     w_ge;
    logic [BACK_DIV_BITS-1:0] w_q;
    logic                     w_last_edge;
    logic                     w_load;
    logic                     w_scale;

    // Edge order: left (x), top (y), right (x), bottom (y)
    assign w_is_y   = r_edge_idx[0];
    assign w_m      = w_is_y ? i_model_height : i_model_width;
    assign w_m1     = (w_m == '0) ? MSIZE_W'(1) : w_m;
    assign w_m_s    = $signed({1'b0, w_m1});
    assign w_c      = w_is_y ? r_job.center_y : r_job.center_x;
    assign w_s      = w_is_y ? r_job.box_height : r_job.box_width;
    assign w_img    = w_is_y ? r_job.image_height : r_job.image_width;
    assign w_c_prod = w_c * w_m_s;
    assign w_s_prod = w_s * w_m_s;

    assign w_c2x2 = {r_c2[45], r_c2, 1'b0};
    assign w_s2e  = {{2{r_s2[45]}}, r_s2};

    assign w_d       = {w_m1, 1'b0};
    assign w_lim     = {w_img, 16'd0};
    assign w_limp1   = {1'b0, w_lim} + 31'd1;
    assign w_num     = {15'd0, r_twice[45:0]} * {47'd0, w_img} + {48'd0, w_m1};
    assign w_limprod = {14'd0, w_limp1} * {31'd0, w_d};
    assign w_over    = r_num >= {16'd0, r_limprod};

    assign w_rem2 = {r_rem, r_dq[BACK_DIV_BITS-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_div_d};
    assign w_q    = {r_dq[BACK_DIV_BITS-2:0], w_ge};

    assign w_last_edge = (r_edge_idx == 2'd3);
    assign w_load      = !r_out_valid || i_out_ready;
    assign w_scale     = (i_job.center_x <= UNIT_Q16) && (i_job.center_y <= UNIT_Q16)
                      && (i_job.box_width <= UNIT_Q16) && (i_job.box_height <= UNIT_Q16);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.detected ? B_SCALE : B_OUT;
                end
            end
            B_SCALE: n_state = B_TWICE;
            B_TWICE: n_state = B_PROD;
            B_PROD:  n_state = B_LIMIT;
            B_LIMIT: begin
                if (!r_pos || w_over) begin
                    n_state = w_last_edge ? B_OUT : B_SCALE;
                end else begin
                    n_state = B_DIV;
                end
            end
            B_DIV: begin
                if (r_cnt == 5'(BACK_DIV_BITS - 1)) begin
                    n_state = w_last_edge ? B_OUT : B_SCALE;
                end
            end
            B_OUT: begin
                if (w_load) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready = (r_state == B_IDLE);
        o_out_valid = r_out_valid;
        o_out_word  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_OUT && w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    r_job      <= i_job;
                    r_scale    <= w_scale;
                    r_edge_idx <= '0;
                end
            end
            B_SCALE: begin
                if (r_scale) begin
                    r_c2 <= w_c_prod;
                    r_s2 <= w_s_prod;
                end else begin
                    r_c2 <= {{14{w_c[GEO_W-1]}}, w_c};
                    r_s2 <= {{14{w_s[GEO_W-1]}}, w_s};
                end
            end
            B_TWICE: begin
                r_twice <= r_edge_idx[1] ? (w_c2x2 + w_s2e) : (w_c2x2 - w_s2e);
            end
            B_PROD: begin
                r_pos     <= !r_twice[47] && (r_twice != '0);
                r_num     <= w_num;
                r_limprod <= w_limprod;
                r_lim     <= w_lim;
                r_div_d   <= w_d;
            end
            B_LIMIT: begin
                if (!r_pos) begin
                    r_edge[r_edge_idx] <= '0;
                    r_edge_idx         <= r_edge_idx + 2'd1;
                end else if (w_over) begin
                    r_edge[r_edge_idx] <= r_lim;
                    r_edge_idx         <= r_edge_idx + 2'd1;
                end else begin
                    r_rem <= r_num[43:BACK_DIV_BITS];
                    r_dq  <= r_num[BACK_DIV_BITS-1:0];
                    r_cnt <= '0;
                end
            end
            B_DIV: begin
                r_rem <= w_ge ? 14'(w_rem2 - {1'b0, r_div_d}) : w_rem2[13:0];
                r_dq  <= w_q;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(BACK_DIV_BITS - 1)) begin
                    r_edge[r_edge_idx] <= w_q;
                    r_edge_idx         <= r_edge_idx + 2'd1;
                end
            end
            B_OUT: begin
                if (w_load) begin
                    r_out.detected       <= r_job.detected;
                    r_out.left           <= r_job.detected ? r_edge[0] : '0;
                    r_out.top            <= r_job.detected ? r_edge[1] : '0;
                    r_out.right          <= r_job.detected ? r_edge[2] : '0;
                    r_out.bottom         <= r_job.detected ? r_edge[3] : '0;
                    r_out.best_score_out <= r_job.score;
                    r_out.best_class_out <= r_job.class_idx;
                    r_out.end_of_image   <= r_job.last_box;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[hdl/detection_box_postprocess.sv]
// Channel | Direction | Handshake                    | Word
// --------+-----------+------------------------------+-----------
// in      | input     | i_in_valid / o_in_ready      | t_in_word
// out     | output    | o_out_valid / i_out_ready    | t_out_word
// cfg     | input     | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// A logit that saturates or no longer competes goes from accept straight to compare; any
// other takes accept, 12 exp multiplier steps, setup, 17 score divider steps, compare.
// After a box's last logit the front hands the box to the queue. The mapper takes each edge
// through scale, twice-centre sum, product, limit and up to 30 steps of the shared divider.
// Reset clears the per-box state, the queue and the output valid flag; no clearing pass.
// A full output register stalls the mapper; a full queue stalls the front after the
// last logit of a box.
`default_nettype none
module detection_box_postprocess
    import dbp_pkg::*;
#(
    parameter int unsigned MAX_CLASSES = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_word              i_in_word,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_word                  o_out_word,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers; the user writes them only while idle; not enforced
    logic [MSIZE_W-1:0] r_model_width;
    logic [MSIZE_W-1:0] r_model_height;
    logic [SCORE_W-1:0] r_score_threshold;

    logic     w_fq_valid;
    logic     w_fq_ready;
    t_box_job w_fq_job;
    logic     w_qb_valid;
    logic     w_qb_ready;
    t_box_job w_qb_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_width     <= MSIZE_W'(640);
            r_model_height    <= MSIZE_W'(640);
            r_score_threshold <= SCORE_W'(32768);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODEL_WIDTH:     r_model_width     <= i_cfg_data[MSIZE_W-1:0];
                CFG_MODEL_HEIGHT:    r_model_height    <= i_cfg_data[MSIZE_W-1:0];
                CFG_SCORE_THRESHOLD: r_score_threshold <= i_cfg_data[SCORE_W-1:0];
                default: ; // drop writes to unmapped indexes
            endcase
        end
    end

    // Front: score each logit, track the best class, hand finished boxes on
    dbp_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_word         (i_in_word),
        .i_score_threshold (r_score_threshold),
        .o_job_valid       (w_fq_valid),
        .i_job_ready       (w_fq_ready),
        .o_job             (w_fq_job)
    );

    // Short queue so scoring of the next box overlaps mapping of this one
    dbp_fifo u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fq_valid),
        .o_wr_ready (w_fq_ready),
        .i_wr_job   (w_fq_job),
        .o_rd_valid (w_qb_valid),
        .i_rd_ready (w_qb_ready),
        .o_rd_job   (w_qb_job)
    );

    // Back: decode, map to image pixels, clamp, hold the result word
    dbp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_qb_valid),
        .o_job_ready    (w_qb_ready),
        .i_job          (w_qb_job),
        .i_model_width  (r_model_width),
        .i_model_height (r_model_height),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_word     (o_out_word)
    );

endmodule
`default_nettype wire

[tb/tb.sv]
`default_nettype none
module tb;
    import dbp_pkg::*;

    // Drain margin covers the mapper's worst case for a box plus a box's last logit.
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned LONG_HOLD    = 3000;
    localparam int unsigned CLASS_CAP    = 256;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    t_in_word       i_in_word;
    logic           o_out_valid;
    logic           i_out_ready;
    t_out_word      o_out_word;
    logic           i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    detection_box_postprocess dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the configuration registers
    logic [MSIZE_W-1:0] model_w_reg;
    logic [MSIZE_W-1:0] model_h_reg;
    logic [SCORE_W-1:0] thresh_reg;

    // Shadow copy of the per-box argmax state
    int unsigned        class_cnt;
    logic [SCORE_W-1:0] top_score;
    logic [CLASS_W-1:0] top_class;
    bit                 any_hit;

    t_out_word box_q[$];   // decoded boxes still owed by the block
    int        n_fail;
    int        n_boxes;
    longint    cycle_cnt;

    // Q0.32 factors exp(-2^(b-8)), one per magnitude bit of the logit
    function automatic longint unsigned exp_factor(int b);
        longint unsigned k[12] = '{
            64'd4278222805, 64'd4261543595, 64'd4228380000, 64'd4162825044,
            64'd4034748382, 64'd3790295335, 64'd3344923893, 64'd2605029347,
            64'd1580030169, 64'd581260615,  64'd78665070,   64'd1440801};
        return k[b];
    endfunction

    function automatic logic [SCORE_W-1:0] logit_score(logic signed [LOGIT_W-1:0] x);
        longint          xs;
        longint unsigned mag, e, den, num, s;
        xs  = longint'(x);
        mag = (xs < 0) ? longint'(-xs) : xs;
        e   = 64'd1 << 32;
        // Saturate at 16.0 and above
        if (mag >= 4096)
            return (xs > 0) ? 16'hFFFF : 16'h0000;
        for (int b = 0; b < 12; b++)
            if (mag[b])
                e = (e * exp_factor(b) + (64'd1 << 31)) >> 32;
        den = (64'd1 << 32) + e;
        num = (xs >= 0) ? (64'd1 << 48) : (e << 16);
        s   = (num + den / 2) / den;
        return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    // Corner from model pixels to image pixels, rounded half up and clamped
    function automatic logic [EDGE_W-1:0] image_edge(longint twice, longint unsigned img,
                                                     longint unsigned msize);
        longint unsigned q, lim;
        if (twice <= 0)
            return '0;
        q   = (longint'(twice) * img + msize) / (2 * msize);
        lim = img << 16;
        if (q > lim)
            q = lim;
        return q[EDGE_W-1:0];
    endfunction

    // Advance the argmax with one logit; on the last logit decode the box
    task automatic predict_word(input t_in_word w, output bit has, output t_out_word r);
        logic [SCORE_W-1:0] s;
        longint             cx, cy, bw, bh;
        longint unsigned    mw, mh;
        has = 1'b0;
        r   = '0;
        if (class_cnt < CLASS_CAP) begin
            s = logit_score(w.class_logit);
            if (s > top_score && s > thresh_reg) begin
                top_score = s;
                top_class = class_cnt[CLASS_W-1:0];
                any_hit   = 1'b1;
            end
            class_cnt++;
        end
        if (!w.last_class)
            return;
        has = 1'b1;
        mw  = (model_w_reg == 0) ? 1 : model_w_reg;
        mh  = (model_h_reg == 0) ? 1 : model_h_reg;
        cx  = longint'(w.center_x);
        cy  = longint'(w.center_y);
        bw  = longint'(w.box_width);
        bh  = longint'(w.box_height);
        r.detected = any_hit;
        if (any_hit) begin
            // Normalized box: scale up to model pixels
            if (cx <= 65536 && cy <= 65536 && bw <= 65536 && bh <= 65536) begin
                cx = cx * longint'(mw);
                bw = bw * longint'(mw);
                cy = cy * longint'(mh);
                bh = bh * longint'(mh);
            end
            r.left           = image_edge(2 * cx - bw, w.image_width, mw);
            r.top            = image_edge(2 * cy - bh, w.image_height, mh);
            r.right          = image_edge(2 * cx + bw, w.image_width, mw);
            r.bottom         = image_edge(2 * cy + bh, w.image_height, mh);
            r.best_score_out = top_score;
            r.best_class_out = top_class;
        end
        r.end_of_image = w.last_box;
        class_cnt = 0;
        top_score = '0;
        top_class = '0;
        any_hit   = 1'b0;
    endtask

    // Offer one word after a random gap and hold it until accepted.
    // A typed expectation, when given, stands in for the predicted box.
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word texp);
        int        gap;
        bit        has;
        t_out_word r;
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predict_word(w, has, r);
        if (has)
            box_q = {box_q, (typed ? texp : r)};
    endtask

    // Drain the block, then write all three registers back to back
    task automatic write_config(input int unsigned mw, input int unsigned mh,
                                input int unsigned thr);
        i_in_valid <= 1'b0;
        while (box_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MODEL_WIDTH;
        i_cfg_data <= CFG_DATA_W'(mw);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MODEL_HEIGHT;
        i_cfg_data <= CFG_DATA_W'(mh);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SCORE_THRESHOLD;
        i_cfg_data <= CFG_DATA_W'(thr);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model_w_reg = mw[MSIZE_W-1:0];
        model_h_reg = mh[MSIZE_W-1:0];
        thresh_reg  = thr[SCORE_W-1:0];
    endtask

    function automatic t_in_word mk_word(int logit, bit lc, bit lb, int cx, int cy,
                                         int bw, int bh, int iw, int ih);
        t_in_word w;
        w.class_logit  = logit[LOGIT_W-1:0];
        w.last_class   = lc;
        w.last_box     = lb;
        w.center_x     = cx;
        w.center_y     = cy;
        w.box_width    = bw;
        w.box_height   = bh;
        w.image_width  = iw[IMG_W-1:0];
        w.image_height = ih[IMG_W-1:0];
        return w;
    endfunction

    function automatic int rand_logit();
        case ($urandom_range(0, 5))
            0:       return $signed(16'($urandom()));
            1:       return $urandom_range(0, 1) ? 4096 : -4096;
            default: return int'($urandom_range(0, 2400)) - 1200;
        endcase
    endfunction

    function automatic int rand_geo(bit normalized);
        if (normalized)
            return $urandom_range(0, 20) == 0 ? 65537 : $urandom_range(0, 65536);
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return -int'($urandom_range(0, 300) << 16);
            default: return $urandom_range(0, 5000) << 16;
        endcase
    endfunction

    function automatic int rand_img();
        return $urandom_range(0, 3) == 0 ? $urandom_range(0, 16383) : $urandom_range(1, 8192);
    endfunction

    // One box of random logits, well formed; noise words are thrown in now and then
    task automatic send_box(input int n_cls);
        t_in_word     w;
        bit           norm;
        logic [223:0] raw;
        norm = $urandom_range(0, 1);
        for (int c = 0; c < n_cls; c++) begin
            if ($urandom_range(0, 19) == 0) begin
                raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom()};
                w = raw[$bits(t_in_word)-1:0];
                send_word(w, 1'b0, '0);
            end
            w = mk_word(rand_logit(), c == n_cls - 1, $urandom_range(0, 1),
                        rand_geo(norm), rand_geo(norm), rand_geo(norm), rand_geo(norm),
                        rand_img(), rand_img());
            send_word(w, 1'b0, '0);
        end
    endtask

    task automatic random_phase(input int n_items, input bit huge_box);
        int sent;
        int n_cls;
        sent = 0;
        if (huge_box) begin
            // Overflow the class counter: indexes past the cap must not compete
            send_box(300);
            sent = 300;
        end
        while (sent < n_items) begin
            n_cls = $urandom_range(1, 6);
            send_box(n_cls);
            sent += n_cls;
        end
    endtask

    // Output side: random stalls, one long hold-off to back the block up
    int rx_wait;
    always @(posedge i_clk) begin : rx_side
        int n;
        n = (rx_wait > 0) ? rx_wait - 1 : 0;
        if (o_out_valid && i_out_ready) begin
            t_out_word e;
            n_boxes++;
            if (box_q.size() == 0) begin
                $error("box with no expectation waiting");
                n_fail++;
            end else begin
                e = box_q.pop_front();
                if (o_out_word.detected != e.detected) begin
                    $error("detected exp %0d got %0d", e.detected, o_out_word.detected);
                    n_fail++;
                end
                if (o_out_word.left != e.left) begin
                    $error("left exp %0d got %0d", e.left, o_out_word.left);
                    n_fail++;
                end
                if (o_out_word.top != e.top) begin
                    $error("top exp %0d got %0d", e.top, o_out_word.top);
                    n_fail++;
                end
                if (o_out_word.right != e.right) begin
                    $error("right exp %0d got %0d", e.right, o_out_word.right);
                    n_fail++;
                end
                if (o_out_word.bottom != e.bottom) begin
                    $error("bottom exp %0d got %0d", e.bottom, o_out_word.bottom);
                    n_fail++;
                end
                if (o_out_word.best_score_out != e.best_score_out) begin
                    $error("best_score_out exp %0d got %0d", e.best_score_out,
                           o_out_word.best_score_out);
                    n_fail++;
                end
                if (o_out_word.best_class_out != e.best_class_out) begin
                    $error("best_class_out exp %0d got %0d", e.best_class_out,
                           o_out_word.best_class_out);
                    n_fail++;
                end
                if (o_out_word.end_of_image != e.end_of_image) begin
                    $error("end_of_image exp %0d got %0d", e.end_of_image,
                           o_out_word.end_of_image);
                    n_fail++;
                end
            end
            n = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4);
            if (n_boxes == 40)
                n = LONG_HOLD;
        end
        rx_wait     <= n;
        i_out_ready <= (n == 0);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL detection_box_postprocess");
            $finish;
        end
    end

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word r;
    } t_dir_row;

    initial begin : main
        t_dir_row dir_tab[17];
        int       one;
        one = 65536;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_out_ready <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_MODEL_WIDTH;
        i_cfg_data  <= '0;
        rx_wait     = 0;
        n_fail      = 0;
        n_boxes     = 0;
        cycle_cnt   = 0;
        model_w_reg = 640;
        model_h_reg = 640;
        thresh_reg  = 16'd32768;
        class_cnt   = 0;
        top_score   = '0;
        top_class   = '0;
        any_hit     = 1'b0;

        // Directed words under reset configuration (640 x 640, threshold 0.5)
        // Most negative logit alone: nothing detected, end of image echoed
        dir_tab[0]  = '{mk_word(-32768, 1, 1, 0, 0, 0, 0, 640, 640), 1'b1,
                        '{1'b0, 30'd0, 30'd0, 30'd0, 30'd0, 16'd0, 8'd0, 1'b1}};
        // Most positive logit saturates; unit box fills the whole image
        dir_tab[1]  = '{mk_word(32767, 1, 0, one / 2, one / 2, one, one, 640, 640), 1'b1,
                        '{1'b1, 30'd0, 30'd0, 30'd41943040, 30'd41943040, 16'hFFFF, 8'd0,
                          1'b0}};
        // Logit zero gives exactly the threshold, which is not exceeded
        dir_tab[2]  = '{mk_word(0, 1, 0, 1000, 1000, 1000, 1000, 640, 640), 1'b1, '0};
        dir_tab[3]  = '{mk_word(1, 1, 0, one / 4, one / 3, one / 8, one / 5, 1920, 1080),
                        1'b0, '0};
        // Tie between the first two classes: the earlier one wins
        dir_tab[4]  = '{mk_word(1024, 0, 0, 0, 0, 0, 0, 1, 1), 1'b0, '0};
        dir_tab[5]  = '{mk_word(1024, 0, 0, 0, 0, 0, 0, 1, 1), 1'b0, '0};
        dir_tab[6]  = '{mk_word(512, 1, 1, one / 2, one / 2, one / 2, one / 2, 800, 600),
                        1'b0, '0};
        // Stray end-of-image flag on a middle logit is ignored
        dir_tab[7]  = '{mk_word(0, 0, 1, 0, 0, 0, 0, 640, 640), 1'b0, '0};
        dir_tab[8]  = '{mk_word(2048, 1, 0, 100 << 16, 200 << 16, 50 << 16, 30 << 16,
                                1280, 720), 1'b0, '0};
        // Box partly off the image on the negative side
        dir_tab[9]  = '{mk_word(4095, 1, 0, -(5 << 16), 300 << 16, 40 << 16, 700 << 16,
                                640, 640), 1'b0, '0};
        dir_tab[10] = '{mk_word(-4095, 1, 1, 0, 0, 0, 0, 640, 640), 1'b1,
                        '{1'b0, 30'd0, 30'd0, 30'd0, 30'd0, 16'd0, 8'd0, 1'b1}};
        // Geometry extremes, largest image
        dir_tab[11] = '{mk_word(4096, 1, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                32'h7FFFFFFF, 16383, 16383), 1'b0, '0};
        dir_tab[12] = '{mk_word(3000, 1, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                                32'h80000000, 8192, 8192), 1'b0, '0};
        // Zero image size collapses every edge
        dir_tab[13] = '{mk_word(2000, 1, 1, one / 2, one / 2, one / 4, one / 4, 0, 0),
                        1'b0, '0};
        // Best class in the middle of the box
        dir_tab[14] = '{mk_word(500, 0, 0, 0, 0, 0, 0, 1, 1), 1'b0, '0};
        dir_tab[15] = '{mk_word(3000, 0, 0, 0, 0, 0, 0, 1, 1), 1'b0, '0};
        dir_tab[16] = '{mk_word(1000, 1, 0, one, one, one, one, 8191, 1), 1'b0, '0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k])
            send_word(dir_tab[k].w, dir_tab[k].typed, dir_tab[k].r);

        // Zero model size behaves as one; everything above zero passes
        write_config(0, 0, 0);
        random_phase(300, 1'b1);
        // Largest sizes, threshold that no score can exceed
        write_config(8191, 8191, 65535);
        random_phase(60, 1'b0);
        write_config(1, 4096, 40000);
        random_phase(50, 1'b0);
        write_config(640, 480, 32768);
        random_phase(50, 1'b0);
        write_config($urandom_range(1, 8191), $urandom_range(1, 8191), $urandom_range(0, 65535));
        random_phase(50, 1'b0);

        i_in_valid <= 1'b0;
        while (box_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_fail == 0 && box_q.size() == 0)
            $display("PASS detection_box_postprocess");
        else
            $display("FAIL detection_box_postprocess");
        $finish;
    end

endmodule
`default_nettype wire
